// File: rtl/core/rws_pkg.sv
// Shared types and constants of the roulette wheel selector.
// No dependencies.
`timescale 1ns / 1ps

package rws_pkg;

  localparam int unsigned MaxEntries = 128;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned ShareW     = 16;
  localparam int unsigned RateW      = FracBits + 1;
  localparam int unsigned IdxOutW    = 7;

  localparam logic [ShareW-1:0] MercyReset   = 16'd3277;
  localparam logic [ShareW-1:0] UnluckyReset = 16'd66;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_REPRO  = 2'd2,
    CMD_KILL   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    CFG_MERCY   = 1'b0,
    CFG_UNLUCKY = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_NS, S_NSF, S_RLO, S_RHI, S_RACC,
    S_PROBE, S_P1, S_P2, S_P3, S_P4, S_CMP
  } state_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [RateW-1:0] rate_value;
    logic [RateW-1:0] draw_value;
  } in_word_t;

  typedef struct packed {
    logic [IdxOutW-1:0] chosen_index;
    status_e            status;
  } out_word_t;

endpackage

// File: rtl/core/rws_mul.sv
// Shared multiplier with registered product.
// No dependencies.
`timescale 1ns / 1ps

module rws_mul #(
  parameter int unsigned MW = 32
) (
  input  logic            clk_i,
  input  logic [MW-1:0]   a_i,
  input  logic [MW-1:0]   b_i,
  output logic [2*MW-1:0] prod_o
);

  logic [2*MW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/core/rws_store.sv
// Prefix-sum table: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module rws_store #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7,
  parameter int unsigned DW    = 24
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/roulette_wheel_selector.sv
// Roulette wheel selector top level: command sequencer, state and compare.
// Depends on rws_pkg, rws_mul and rws_store.
`timescale 1ns / 1ps

// Clear and append never leave the idle state; the result strobes on done_o the
// cycle after start. A draw runs a binary search over the stored prefix sums
// on one shared multiplier: setup states S_NS, S_NSF, S_RLO, S_RHI and S_RACC,
// then S_PROBE, S_P1 to S_P4 and S_CMP per probe, about ceil(log2(n)) probes. The
// result shows on done_o for exactly one cycle and must be taken then; busy
// drops in the same cycle, so the next start may be given alongside it.
module roulette_wheel_selector #(
  parameter int unsigned MAX_ENTRIES = rws_pkg::MaxEntries
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  rws_pkg::in_word_t               in_i,
  output logic                            done_o,
  output rws_pkg::out_word_t              out_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [rws_pkg::ShareW-1:0]      cfg_data_i
);

  localparam int unsigned FRAC_BITS = rws_pkg::FracBits;
  localparam int unsigned IDXW = $clog2(MAX_ENTRIES);
  localparam int unsigned CNTW = IDXW + 1;
  localparam int unsigned SUMW = CNTW + FRAC_BITS;
  localparam int unsigned MWA  = CNTW + SUMW;
  localparam int unsigned MWB  = IDXW + rws_pkg::ShareW;
  localparam int unsigned MW   = (MWA > MWB) ? MWA : MWB;
  localparam int unsigned FW   = ((FRAC_BITS > rws_pkg::ShareW) ? FRAC_BITS
                                  : rws_pkg::ShareW) + 1;
  localparam int unsigned CW   = 2 * MW + 2 * FRAC_BITS + 18;
  localparam int unsigned RXW  = SUMW + rws_pkg::RateW;

  localparam logic [CNTW-1:0] MaxCount = CNTW'(MAX_ENTRIES);
  localparam logic [RXW-1:0]  OneX     = RXW'(1) << FRAC_BITS;
  localparam logic [FW-1:0]   OneF     = FW'(1) << FRAC_BITS;

  rws_pkg::state_e state_q, state_d;

  logic [rws_pkg::ShareW-1:0] mercy_q, unlucky_q;
  logic [CNTW-1:0]            count_q;
  logic [SUMW-1:0]            total_q;
  logic                       kill_q, zero_q;
  logic [rws_pkg::RateW-1:0]  draw_q;
  logic [SUMW-1:0]            s_q;
  logic [rws_pkg::ShareW-1:0] w_q;
  logic [IDXW-1:0]            lo_q, hi_q, k_q;
  logic [MW+FW-1:0]           r2_q;
  logic [CW-1:0]              rhs_q, lhs_q;
  logic                       done_q;
  rws_pkg::out_word_t         out_q;

  logic [MW-1:0]   mul_a, mul_b;
  logic [2*MW-1:0] prod;
  logic [SUMW-1:0] rd_data;
  logic [IDXW-1:0] mid;
  logic [CNTW-1:0] span;
  logic [CNTW-1:0] mid_w;
  logic            accept;
  logic            is_draw;
  logic [RXW-1:0]  rate_x;
  logic [SUMW-1:0] rate_sat;
  logic [SUMW-1:0] s_kill;
  logic [SUMW-1:0] p_val;
  logic [IDXW-1:0] lo_n, hi_n;
  logic            le;
  logic [IDXW+rws_pkg::IdxOutW-1:0] lo_wide;
  logic            store_we;

  assign accept  = start && (state_q == rws_pkg::S_IDLE);
  assign busy    = (state_q != rws_pkg::S_IDLE);
  assign is_draw = (in_i.cmd == rws_pkg::CMD_REPRO) || (in_i.cmd == rws_pkg::CMD_KILL);

  assign rate_x   = {{SUMW{1'b0}}, in_i.rate_value};
  assign rate_sat = (rate_x > OneX) ? OneX[SUMW-1:0] : rate_x[SUMW-1:0];
  assign s_kill   = {count_q, {FRAC_BITS{1'b0}}} - total_q;

  assign span  = {1'b0, hi_q} - {1'b0, lo_q} + CNTW'(1);
  assign mid_w = {1'b0, lo_q} + {1'b0, span[CNTW-1:1]};
  assign mid   = mid_w[IDXW-1:0];

  assign p_val = kill_q ? ({1'b0, k_q, {FRAC_BITS{1'b0}}} - rd_data) : rd_data;
  assign le    = (lhs_q <= rhs_q);
  assign lo_n  = le ? k_q : lo_q;
  assign hi_n  = le ? hi_q : (k_q - IDXW'(1));

  assign store_we = accept && (in_i.cmd == rws_pkg::CMD_APPEND) && (count_q < MaxCount);
  assign lo_wide  = {{rws_pkg::IdxOutW{1'b0}}, lo_q};

  rws_mul #(.MW(MW)) u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  rws_store #(.DEPTH(MAX_ENTRIES), .AW(IDXW), .DW(SUMW)) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (count_q[IDXW-1:0]),
    .wdata_i (total_q),
    .raddr_i (mid),
    .rdata_o (rd_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rws_pkg::S_IDLE:  if (accept && is_draw && (count_q != '0)) state_d = rws_pkg::S_NS;
      rws_pkg::S_NS:    state_d = rws_pkg::S_NSF;
      rws_pkg::S_NSF:   state_d = rws_pkg::S_RLO;
      rws_pkg::S_RLO:   state_d = rws_pkg::S_RHI;
      rws_pkg::S_RHI:   state_d = rws_pkg::S_RACC;
      rws_pkg::S_RACC:  state_d = (lo_q < hi_q) ? rws_pkg::S_PROBE : rws_pkg::S_IDLE;
      rws_pkg::S_PROBE: state_d = rws_pkg::S_P1;
      rws_pkg::S_P1:    state_d = rws_pkg::S_P2;
      rws_pkg::S_P2:    state_d = rws_pkg::S_P3;
      rws_pkg::S_P3:    state_d = rws_pkg::S_P4;
      rws_pkg::S_P4:    state_d = rws_pkg::S_CMP;
      rws_pkg::S_CMP:   state_d = (lo_n < hi_n) ? rws_pkg::S_PROBE : rws_pkg::S_IDLE;
      default:          state_d = rws_pkg::S_IDLE;
    endcase
  end

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      rws_pkg::S_NS: begin
        mul_a = MW'(count_q);
        mul_b = MW'(s_q);
      end
      rws_pkg::S_NSF: begin
        mul_a = prod[MW-1:0];
        mul_b = zero_q ? MW'(OneF) : MW'(OneF + FW'(w_q));
      end
      rws_pkg::S_RLO: begin
        mul_a = prod[MW-1:0];
        mul_b = MW'(draw_q);
      end
      rws_pkg::S_RHI: begin
        mul_a = MW'(r2_q[MW+FW-1:MW]);
        mul_b = MW'(draw_q);
      end
      rws_pkg::S_P1: begin
        mul_a = MW'(p_val);
        mul_b = MW'(count_q);
      end
      rws_pkg::S_P2: begin
        mul_a = MW'(k_q);
        mul_b = MW'(w_q);
      end
      rws_pkg::S_P3: begin
        mul_a = prod[MW-1:0];
        mul_b = MW'(s_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rws_pkg::S_IDLE;
      mercy_q   <= rws_pkg::MercyReset;
      unlucky_q <= rws_pkg::UnluckyReset;
      count_q   <= '0;
      total_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (cfg_we_i) begin
        unique case (rws_pkg::cfg_idx_e'(cfg_idx_i))
          rws_pkg::CFG_MERCY:   mercy_q   <= cfg_data_i;
          rws_pkg::CFG_UNLUCKY: unlucky_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        unique case (in_i.cmd)
          rws_pkg::CMD_CLEAR: begin
            count_q <= '0;
            total_q <= '0;
            done_q  <= 1'b1;
          end
          rws_pkg::CMD_APPEND: begin
            if (count_q < MaxCount) begin
              count_q <= count_q + CNTW'(1);
              total_q <= total_q + rate_sat;
            end
            done_q <= 1'b1;
          end
          default: if (count_q == '0) done_q <= 1'b1;
        endcase
      end
      if ((state_q == rws_pkg::S_RACC && !(lo_q < hi_q)) ||
          (state_q == rws_pkg::S_CMP && !(lo_n < hi_n))) begin
        done_q <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.chosen_index <= '0;
      out_q.status       <= rws_pkg::STAT_OK;
      unique case (in_i.cmd)
        rws_pkg::CMD_CLEAR: ;
        rws_pkg::CMD_APPEND: begin
          if (count_q < MaxCount) begin
            out_q.chosen_index <= rws_pkg::IdxOutW'(count_q);
          end else begin
            out_q.status <= rws_pkg::STAT_FULL;
          end
        end
        default: if (count_q == '0) out_q.status <= rws_pkg::STAT_EMPTY;
      endcase
      kill_q <= (in_i.cmd == rws_pkg::CMD_KILL);
      draw_q <= in_i.draw_value;
      lo_q   <= '0;
      hi_q   <= IDXW'(count_q - CNTW'(1));
      if (in_i.cmd == rws_pkg::CMD_KILL) begin
        zero_q <= (s_kill == '0);
        s_q    <= (s_kill == '0) ? SUMW'(OneF) : s_kill;
        w_q    <= unlucky_q;
      end else begin
        zero_q <= (total_q == '0);
        s_q    <= (total_q == '0) ? SUMW'(OneF) : total_q;
        w_q    <= mercy_q;
      end
    end
    unique case (state_q)
      rws_pkg::S_RLO:   r2_q  <= prod[MW+FW-1:0];
      rws_pkg::S_RHI:   rhs_q <= CW'(prod);
      rws_pkg::S_RACC: begin
        rhs_q <= rhs_q + (CW'(prod) << MW);
        if (!(lo_q < hi_q)) out_q.chosen_index <= lo_wide[rws_pkg::IdxOutW-1:0];
      end
      rws_pkg::S_PROBE: k_q   <= mid;
      rws_pkg::S_P2:    lhs_q <= CW'(prod) << FRAC_BITS;
      rws_pkg::S_P4:    lhs_q <= (lhs_q + CW'(prod)) << FRAC_BITS;
      rws_pkg::S_CMP: begin
        lo_q <= lo_n;
        hi_q <= hi_n;
        if (!(lo_n < hi_n)) begin
          out_q.chosen_index <= rws_pkg::IdxOutW'({{rws_pkg::IdxOutW{1'b0}}, lo_n});
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign out_o  = out_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobed while busy");

  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (out_o.status != rws_pkg::STAT_OK)) |-> (out_o.chosen_index == '0))
    else $error("flagged result with nonzero index");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCount)
    else $error("entry count above table size");

  a_probe_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rws_pkg::S_PROBE) |-> (lo_q < hi_q))
    else $error("probe with empty search span");

endmodule

// File: tb/sv/rws_checker.sv
// Checker for the roulette wheel selector: predicts each result word and compares.
// Depends on rws_pkg; watches the command, result and configuration ports.
`timescale 1ns / 1ps

module rws_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  rws_pkg::in_word_t           in_i,
  input  logic                        done_i,
  input  rws_pkg::out_word_t          out_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [rws_pkg::ShareW-1:0]  cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import rws_pkg::*;

  localparam longint unsigned One = 64'd1 << FracBits;

  logic [23:0]       prefix_sum [MaxEntries];
  int unsigned       n_entries;
  longint unsigned   sum_rates;
  logic [ShareW-1:0] mercy, unlucky;
  out_word_t         want_q[$];

  assign pending_o = want_q.size();

  function automatic bit cum_at_most(int unsigned k, longint unsigned draw, bit kill);
    longint unsigned p, s, w, n;
    bit zero;
    logic [127:0] lhs, rhs;
    n = n_entries;
    if (kill) begin
      p = k * One - prefix_sum[k];
      s = n * One - sum_rates;
      w = unlucky;
    end else begin
      p = prefix_sum[k];
      s = sum_rates;
      w = mercy;
    end
    zero = (s == 0);
    if (zero) s = One;
    lhs = 128'(p) * 128'(n * One) + 128'(k) * 128'(w) * 128'(s);
    lhs = lhs * 128'(One);
    if (zero) rhs = 128'(n * One) * 128'(One);
    else rhs = 128'(n * s) * 128'(One + w);
    rhs = rhs * 128'(draw);
    return lhs <= rhs;
  endfunction

  function automatic out_word_t predict_word(in_word_t w);
    out_word_t r;
    longint unsigned rt;
    int unsigned lo, hi, mid;
    r.chosen_index = '0;
    r.status = STAT_OK;
    case (w.cmd)
      CMD_CLEAR: begin
        n_entries = 0;
        sum_rates = 0;
      end
      CMD_APPEND: begin
        if (n_entries >= MaxEntries) r.status = STAT_FULL;
        else begin
          rt = w.rate_value;
          if (rt > One) rt = One;
          prefix_sum[n_entries] = sum_rates[23:0];
          sum_rates += rt;
          r.chosen_index = n_entries[IdxOutW-1:0];
          n_entries++;
        end
      end
      default: begin
        if (n_entries == 0) r.status = STAT_EMPTY;
        else begin
          lo = 0;
          hi = n_entries - 1;
          while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (cum_at_most(mid, w.draw_value, w.cmd == CMD_KILL)) lo = mid;
            else hi = mid - 1;
          end
          r.chosen_index = lo[IdxOutW-1:0];
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t e;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      n_entries = 0;
      sum_rates = 0;
      mercy <= MercyReset;
      unlucky <= UnluckyReset;
      fail_count_o <= 0;
      want_q.delete();
    end else begin
      if (done_i) begin
        if (want_q.size() == 0) begin
          $error("unexpected result word: index %0d status %0d",
                 out_i.chosen_index, out_i.status);
          errs++;
        end else begin
          e = want_q.pop_front();
          if (out_i.chosen_index !== e.chosen_index) begin
            $error("chosen_index: expected %0d, actual %0d", e.chosen_index,
                   out_i.chosen_index);
            errs++;
          end
          if (out_i.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, out_i.status);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      if (start_i && !busy_i) want_q.push_back(predict_word(in_i));
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MERCY) mercy <= cfg_data_i;
        else unlucky <= cfg_data_i;
      end
    end
  end
endmodule

// File: tb/sv/testbench.sv
// Top of the roulette wheel selector testbench: clock, reset, commands, verdict.
// Depends on rws_pkg, rws_checker and roulette_wheel_selector.
`timescale 1ns / 1ps

module testbench;
  import rws_pkg::*;

  localparam int IdleLimit = 4000;

  logic              clk, rst_n, start, busy, done, cfg_we, cfg_idx;
  logic [ShareW-1:0] cfg_data;
  in_word_t          cmd_word;
  out_word_t         res_word;
  int                fail_count, pending, quiet_cycles, idle_pct, fill;

  roulette_wheel_selector dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy), .in_i(cmd_word),
    .done_o(done), .out_o(res_word), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data)
  );

  rws_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy), .in_i(cmd_word),
    .done_i(done), .out_i(res_word), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic send_word(cmd_e c, logic [RateW-1:0] r, logic [RateW-1:0] d);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd_word <= '{cmd: c, rate_value: r, draw_value: d};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [ShareW-1:0] val);
    drain_results();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [RateW-1:0] pick_q16();
    case ($urandom_range(5))
      0: return '0;
      1: return 17'h10000;
      2: return RateW'($urandom_range(17'h1FFFF, 17'h10001));
      default: return RateW'($urandom_range(17'h10000));
    endcase
  endfunction

  initial begin
    start = 0;
    cfg_we = 0;
    cfg_idx = 0;
    cfg_data = 0;
    cmd_word = '0;
    idle_pct = 0;
    rst_n = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed
    send_word(CMD_REPRO, '0, 17'h10000);
    send_word(CMD_KILL, '0, '0);
    send_word(CMD_APPEND, '0, '0);
    send_word(CMD_APPEND, '0, '0);
    send_word(CMD_REPRO, '0, 17'h08000);
    send_word(CMD_KILL, '0, 17'h1FFFF);
    send_word(CMD_CLEAR, '0, '0);
    send_word(CMD_APPEND, 17'h10000, '0);
    send_word(CMD_APPEND, 17'h1FFFF, '0);
    send_word(CMD_KILL, '0, 17'h08000);
    send_word(CMD_REPRO, '0, 17'h1FFFF);
    send_word(CMD_APPEND, 17'h04000, '0);
    send_word(CMD_REPRO, '0, '0);
    send_word(CMD_KILL, '0, 17'h10000);
    send_word(CMD_CLEAR, '0, '0);
    for (int i = 0; i < 129; i++) send_word(CMD_APPEND, RateW'($urandom_range(17'h10000)), '0);
    send_word(CMD_REPRO, '0, 17'h10000);
    send_word(CMD_KILL, '0, 17'h0ABCD);
    write_cfg(CFG_MERCY, 16'hFFFF);
    write_cfg(CFG_UNLUCKY, 16'h0000);
    // random phases over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 51;
        2: idle_pct = 10;
        default: idle_pct = 51;
      endcase
      if (ph == 2) write_cfg(CFG_MERCY, 16'h0000);
      if (ph == 3) write_cfg(CFG_UNLUCKY, 16'hFFFF);
      if (ph == 4) begin
        write_cfg(CFG_MERCY, 16'($urandom));
        write_cfg(CFG_UNLUCKY, 16'($urandom));
      end
      if (ph == 6) begin
        write_cfg(CFG_MERCY, MercyReset);
        write_cfg(CFG_UNLUCKY, UnluckyReset);
      end
      send_word(CMD_CLEAR, RateW'($urandom), RateW'($urandom));
      fill = ($urandom_range(7) == 0) ? 130 : $urandom_range(1, 12);
      for (int i = 0; i < fill; i++)
        send_word(CMD_APPEND, pick_q16(), RateW'($urandom));
      for (int i = 0; i < 50; i++) begin
        case ($urandom_range(19))
          0: send_word(CMD_CLEAR, RateW'($urandom), RateW'($urandom));
          1, 2, 3: send_word(CMD_APPEND, pick_q16(), RateW'($urandom));
          4, 5, 6, 7, 8, 9, 10, 11: send_word(CMD_REPRO, RateW'($urandom), pick_q16());
          default: send_word(CMD_KILL, RateW'($urandom), pick_q16());
        endcase
      end
      if (ph == 5) drain_results();
    end
    drain_results();
    if (fail_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule

// File: sim.f
rtl/core/rws_pkg.sv
rtl/core/rws_mul.sv
rtl/core/rws_store.sv
rtl/core/roulette_wheel_selector.sv
tb/sv/rws_checker.sv
tb/sv/testbench.sv
